// ----- rtl/bcdcal_pkg.sv -----
// bcdcal_pkg: shared types and constants for the bcd clock to calendar block
// no dependencies; imported by the decode, date and top level modules

package bcdcal_pkg;

    // range limits on the decoded fields
    localparam int unsigned SEC_MAX     = 59;
    localparam int unsigned MIN_MAX     = 59;
    localparam int unsigned HOUR_MAX    = 23;
    localparam int unsigned DAY_MAX     = 31;
    localparam int unsigned MONTH_MAX   = 12;
    localparam int unsigned CENTURY     = 100;
    // last accepted year is 2036, i.e. offset 36 from 2000
    localparam int unsigned YEAR_OFS_MAX = 2036 - 2000;

    // 2000-01-01 is a saturday (6); day numbers count from day 1, so base is 6 - 1
    localparam int unsigned WDAY_BASE   = 5;

    // month codes used by the day-of-year table and the leap-day check
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;

    // decoded reading, handed from the decoder to the date logic
    typedef struct packed {
        logic       ok;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [5:0] year;
    } dec_t;

    // one finished result
    typedef struct packed {
        logic       valid_res;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [4:0] day_of_month;
        logic [3:0] month_number;
        logic [5:0] year_offset;
        logic [8:0] year_day;
        logic [2:0] week_day;
    } res_t;

endpackage

// ----- rtl/bcdcal_decode.sv -----
// bcdcal_decode: converts six bcd bytes to binary and range-checks them
// depends on bcdcal_pkg

module bcdcal_decode
    import bcdcal_pkg::*;
(
    input  logic [7:0] sec_bcd,
    input  logic [7:0] min_bcd,
    input  logic [7:0] hour_bcd,
    input  logic [7:0] day_bcd,
    input  logic [7:0] month_bcd,
    input  logic [7:0] year_bcd,
    output dec_t       dec
);

    // tens*10 + units; nibbles above nine are not rejected, max 165
    function automatic logic [7:0] bcd2bin(input logic [7:0] b);
        logic [7:0] tens;
        begin
            tens = {4'd0, b[7:4]};
            bcd2bin = (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
        end
    endfunction

    logic [7:0] sec_bin;
    logic [7:0] min_bin;
    logic [7:0] hour_bin;
    logic [7:0] day_bin;
    logic [7:0] month_bin;
    logic [7:0] year_raw;
    logic [7:0] year_bin;

    // binary conversion
    always_comb
    begin
        sec_bin   = bcd2bin(sec_bcd);
        min_bin   = bcd2bin(min_bcd);
        hour_bin  = bcd2bin(hour_bcd);
        day_bin   = bcd2bin(day_bcd);
        month_bin = bcd2bin(month_bcd);
        year_raw  = bcd2bin(year_bcd);
    end

    // year mod 100: raw value stays below twice the century
    assign year_bin = (year_raw >= 8'(CENTURY)) ? (year_raw - 8'(CENTURY)) : year_raw;

    // range checks and field packing
    always_comb
    begin
        dec.ok    = (sec_bin   <= 8'(SEC_MAX))   &&
                    (min_bin   <= 8'(MIN_MAX))   &&
                    (hour_bin  <= 8'(HOUR_MAX))  &&
                    (day_bin   <= 8'(DAY_MAX))   &&
                    (month_bin <= 8'(MONTH_MAX)) &&
                    (year_bin  <= 8'(YEAR_OFS_MAX));
        dec.sec   = sec_bin[5:0];
        dec.min   = min_bin[5:0];
        dec.hour  = hour_bin[4:0];
        dec.day   = day_bin[4:0];
        dec.month = month_bin[3:0];
        dec.year  = year_bin[5:0];
    end

endmodule

// ----- rtl/bcdcal_date.sv -----
// bcdcal_date: day of year and weekday from a decoded reading, zeroing on a failed check
// depends on bcdcal_pkg

module bcdcal_date
    import bcdcal_pkg::*;
(
    input  dec_t dec,
    output res_t res
);

    // days in the months before the given one, non-leap year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        begin
            unique case (m)
                4'd3:    cum_days = 9'd59;
                4'd4:    cum_days = 9'd90;
                4'd5:    cum_days = 9'd120;
                4'd6:    cum_days = 9'd151;
                4'd7:    cum_days = 9'd181;
                4'd8:    cum_days = 9'd212;
                4'd9:    cum_days = 9'd243;
                4'd10:   cum_days = 9'd273;
                4'd11:   cum_days = 9'd304;
                4'd12:   cum_days = 9'd334;
                MONTH_FEB: cum_days = 9'd31;
                default: cum_days = 9'd0;
            endcase
        end
    endfunction

    // mod 7 by folding octal digits (8 == 1 mod 7)
    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        begin
            s1 = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
            s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
            mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
        end
    endfunction

    logic       leap_add;
    logic [8:0] yday;
    logic [3:0] leap_cnt;
    logic [8:0] wsum;

    // day of year; february gains a day when the year offset is a multiple of four
    assign leap_add = (dec.year[1:0] == 2'd0) && (dec.month >= MONTH_MAR);
    assign yday     = cum_days(dec.month) + 9'(leap_add) + 9'(dec.day);

    // leap days before this year: (y + 3) / 4; 365 is 1 mod 7
    assign leap_cnt = 4'((7'(dec.year) + 7'd3) >> 2);
    assign wsum     = 9'(dec.year) + 9'(leap_cnt) + yday + 9'(WDAY_BASE);

    // result, all zero when a check failed
    always_comb
    begin
        if (dec.ok)
        begin
            res.valid_res    = 1'b1;
            res.seconds      = dec.sec;
            res.minutes      = dec.min;
            res.hours        = dec.hour;
            res.day_of_month = dec.day;
            res.month_number = dec.month;
            res.year_offset  = dec.year;
            res.year_day     = yday;
            res.week_day     = mod7(wsum);
        end
        else
        begin
            res = '0;
        end
    end

endmodule

// ----- rtl/bcd_clock_to_calendar.sv -----
// bcd_clock_to_calendar: top level, input register, conversion logic, result register
// depends on bcdcal_pkg, bcdcal_decode, bcdcal_date
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_ready  | sec_bcd min_bcd hour_bcd day_bcd month_bcd year_bcd
//  out     | out_valid/out_ready| valid_res seconds minutes hours day_of_month
//          |                    | month_number year_offset year_day week_day
//
// one request per cycle unless out_ready stalls; out_valid rises once an accepted request moves from the input
// register into the result register; the input register and the result register form a two-stage pipeline
// reset clears both stage valid flags; payload registers are not reset
// a stall on out_ready holds the result; in_ready stays high while the input stage is empty or can move

module bcd_clock_to_calendar
    import bcdcal_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] sec_bcd,
    input  logic [7:0] min_bcd,
    input  logic [7:0] hour_bcd,
    input  logic [7:0] day_bcd,
    input  logic [7:0] month_bcd,
    input  logic [7:0] year_bcd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res,
    output logic [5:0] seconds,
    output logic [5:0] minutes,
    output logic [4:0] hours,
    output logic [4:0] day_of_month,
    output logic [3:0] month_number,
    output logic [5:0] year_offset,
    output logic [8:0] year_day,
    output logic [2:0] week_day
);

    logic       in_vld_reg;
    logic       out_vld_reg;
    logic [7:0] sec_reg;
    logic [7:0] min_reg;
    logic [7:0] hour_reg;
    logic [7:0] day_reg;
    logic [7:0] month_reg;
    logic [7:0] year_reg;
    res_t       res_reg;
    res_t       res_next;
    dec_t       dec;
    logic       adv_out;
    logic       take_in;

    // pipeline flow control
    assign adv_out  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || adv_out;
    assign take_in  = in_valid && in_ready;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (adv_out)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            sec_reg   <= sec_bcd;
            min_reg   <= min_bcd;
            hour_reg  <= hour_bcd;
            day_reg   <= day_bcd;
            month_reg <= month_bcd;
            year_reg  <= year_bcd;
        end
    end

    // conversion logic
    bcdcal_decode u_decode (
        .sec_bcd   (sec_reg),
        .min_bcd   (min_reg),
        .hour_bcd  (hour_reg),
        .day_bcd   (day_reg),
        .month_bcd (month_reg),
        .year_bcd  (year_reg),
        .dec       (dec)
    );

    bcdcal_date u_date (
        .dec (dec),
        .res (res_next)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (adv_out)
            res_reg <= res_next;
    end

    assign out_valid    = out_vld_reg;
    assign valid_res    = res_reg.valid_res;
    assign seconds      = res_reg.seconds;
    assign minutes      = res_reg.minutes;
    assign hours        = res_reg.hours;
    assign day_of_month = res_reg.day_of_month;
    assign month_number = res_reg.month_number;
    assign year_offset  = res_reg.year_offset;
    assign year_day     = res_reg.year_day;
    assign week_day     = res_reg.week_day;

    // a rejected reading carries all-zero fields
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> (seconds == 6'd0) && (minutes == 6'd0) &&
            (hours == 5'd0) && (day_of_month == 5'd0) && (month_number == 4'd0) &&
            (year_offset == 6'd0) && (year_day == 9'd0) && (week_day == 3'd0))
        else $error("rejected reading with nonzero fields");

    // accepted readings stay within calendar limits
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> (week_day <= 3'd6) && (year_day <= 9'd366) &&
            (month_number <= 4'd12) && (year_offset <= 6'd36))
        else $error("result field out of range");

    // the input stage is full whenever a request is refused
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_vld_reg && out_vld_reg && !out_ready)
        else $error("in_ready low with room in the pipeline");

    // a moved request shows up at the output next cycle
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv_out |=> out_vld_reg)
        else $error("advanced request lost");

endmodule
